// ===== sv/lrftb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lrftb_pkg;

	// Event codes carried in the operation field.
	typedef enum logic [1:0] {
		OP_PRECHECK = 2'd0,
		OP_OUTCOME  = 2'd1,
		OP_RELOAD   = 2'd2,
		OP_CLEAR    = 2'd3
	} op_t;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_PREF_RATE = 3'd0,
		REG_TICK_HZ   = 3'd1,
		REG_CLIMB     = 3'd2,
		REG_DROP      = 3'd3,
		REG_FAILS     = 3'd4
	} reg_idx_t;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 10;

	// Rate tiers.
	localparam logic [3:0] RATE_11M  = 4'd3;
	localparam logic [3:0] RATE_6M   = 4'd4;
	localparam logic [3:0] RATE_24M  = 4'd6;
	localparam logic [3:0] RATE_MCS0 = 4'd7;
	localparam logic [3:0] RATE_MCS3 = 4'd8;

	localparam logic [2:0] LEVEL_MAX = 3'd4;

	// Cooldown durations are multiples of 500 ms, so ms * hz / 1000 equals
	// (units * hz) / 2 with units counted in half seconds.
	localparam int unsigned TICKS_W = 14;

	typedef struct packed {
		op_t         operation;
		logic [31:0] now_ticks;
		logic        to_bridge_peer;
		logic        discovery;
		logic        delivered;
		logic        got_reply;
		logic        session_open;
		logic        link_ready;
	} evt_t;

	typedef struct packed {
		logic       send_allowed;
		logic [1:0] attempts_allowed;
		logic [3:0] current_rate;
		logic       rate_changed;
		logic       close_session;
		logic [2:0] cooldown_stage;
	} res_t;

	// Cooldown duration of a level, in half seconds.
	function automatic logic [4:0] cool_units(input logic [2:0] level);
		logic [4:0] u;
		case (level)
			3'd0:    u = 5'd1;
			3'd1:    u = 5'd2;
			3'd2:    u = 5'd4;
			3'd3:    u = 5'd10;
			default: u = 5'd30;
		endcase
		return u;
	endfunction

	// A preferred rate above the top tier acts as the 11M floor.
	function automatic logic [3:0] pref_eff(input logic [3:0] p);
		return (p > RATE_MCS3) ? RATE_11M : p;
	endfunction

	function automatic logic [3:0] tier_down(input logic [3:0] r);
		logic [3:0] t;
		if (r >= RATE_MCS3) begin
			t = RATE_MCS0;
		end else if (r == RATE_MCS0) begin
			t = RATE_24M;
		end else if (r > RATE_11M) begin
			t = r - 4'd1;
		end else begin
			t = RATE_11M;
		end
		return t;
	endfunction

	function automatic logic [3:0] tier_up(input logic [3:0] r, input logic [3:0] p);
		logic [3:0] t;
		if (r >= p) begin
			t = p;
		end else if (r == RATE_MCS0) begin
			t = (p >= RATE_MCS3) ? RATE_MCS3 : p;
		end else if (r >= RATE_6M && r < RATE_MCS0) begin
			t = r + 4'd1;
		end else if (r < RATE_6M) begin
			t = RATE_6M;
		end else begin
			t = p;
		end
		return t;
	endfunction

endpackage

`default_nettype wire

// ===== sv/link_rate_fallback_and_tx_backoff.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Link rate fallback and transmit backoff. Each transfer on the event channel
// is one event (pre-send check, send outcome, peer reload or cooldown clear)
// and yields exactly one result transfer, in order. The block takes one event
// per clock cycle unless stalled; each event is held in the event register,
// then its result in the result register, which offers it on the output. The
// event side is stalled only while a result waits at the output and the event
// register is full. The per-cycle rate is set by the state update loop: the
// streak counters, the rate tier and the cooldown end tick are read and
// written back in the same cycle so the next event sees them. Cooldown
// lengths come from tick_rate_hz by a small constant multiply and a shift, no
// divider. The cooldown end tick is TICK_BITS wide and wraps at that width;
// the incoming tick count is truncated to it when TICK_BITS is below 32.
// Configuration writes take effect at once and must only be made while no
// event is in flight.
module link_rate_fallback_and_tx_backoff
	import lrftb_pkg::*;
#(
	parameter int unsigned TICK_BITS = 32	// 16 to 64
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic                  evt_valid,
	output logic                       evt_stall,
	input  wire evt_t                  evt,
	output logic                       res_valid,
	input  wire logic                  res_stall,
	output res_t                       res
);

	// Configuration registers.
	logic [3:0] pref_q;
	logic [9:0] tick_hz_q;
	logic [7:0] climb_q;
	logic [7:0] drop_q;
	logic [7:0] fails_q;

	// Event register and result register.
	evt_t evt_s1;
	logic vld_s1;
	res_t res_q;
	logic res_vld_q;

	// Adaptation state.
	logic [3:0]           rate_q, rate_d;
	logic [7:0]           rf_q, rf_d;
	logic [7:0]           rok_q, rok_d;
	logic [7:0]           txf_q, txf_d;
	logic [2:0]           lvl_q, lvl_d;
	logic [TICK_BITS-1:0] end_q, end_d;

	logic advance;
	logic fire;

	logic [TICK_BITS+31:0] now_ext;
	logic [TICK_BITS-1:0]  now_tk;
	logic                  cooling;
	logic                  cnc;
	logic                  ok;
	logic [3:0]            pref_e;
	logic [7:0]            rok_inc;
	logic [7:0]            rf_inc;
	logic [7:0]            txf_inc;
	logic [2:0]            lvl_up;
	logic [14:0]           cool_prod;
	logic [TICKS_W-1:0]    cool_ticks;

	logic       allowed;
	logic [1:0] attempts;
	logic       stop;
	logic       changed;
	logic       apply_req;
	logic [3:0] target;

	// The result register frees up when it is empty or its transfer completes.
	assign advance   = !res_vld_q || !res_stall;
	assign fire      = vld_s1 && advance;
	assign evt_stall = vld_s1 && !advance;
	assign res_valid = res_vld_q;
	assign res       = res_q;

	// Tick count cut or extended to the cooldown tick width.
	assign now_ext = {{TICK_BITS{1'b0}}, evt_s1.now_ticks};
	assign now_tk  = now_ext[TICK_BITS-1:0];

	// A zero end tick means no cooldown; the compare does not wrap.
	assign cooling = (end_q != '0) && (now_tk < end_q);
	assign cnc     = evt_s1.to_bridge_peer && !evt_s1.discovery;
	assign ok      = !evt_s1.discovery && evt_s1.delivered;
	assign pref_e  = pref_eff(pref_q);

	assign rok_inc = rok_q + 8'd1;
	assign rf_inc  = rf_q + 8'd1;
	assign txf_inc = txf_q + 8'd1;
	assign lvl_up  = (lvl_q < LEVEL_MAX) ? lvl_q + 3'd1 : lvl_q;

	// Cooldown length in ticks for the escalated level.
	assign cool_prod  = 15'(cool_units(lvl_up)) * 15'(tick_hz_q);
	assign cool_ticks = cool_prod[14:1];

	always_comb begin
		rate_d    = rate_q;
		rf_d      = rf_q;
		rok_d     = rok_q;
		txf_d     = txf_q;
		lvl_d     = lvl_q;
		end_d     = end_q;
		allowed   = 1'b0;
		attempts  = 2'd0;
		stop      = 1'b0;
		changed   = 1'b0;
		apply_req = 1'b0;
		target    = rate_q;
		case (evt_s1.operation)
			OP_PRECHECK: begin
				// Bridge traffic other than discovery waits out a cooldown.
				allowed  = !(cnc && cooling);
				attempts = (evt_s1.discovery || txf_q != '0 || lvl_q != '0) ?
					2'd1 : 2'd2;
			end
			OP_OUTCOME: begin
				// Only bridge sends adapt the rate; discovery counts as failed.
				if (evt_s1.to_bridge_peer) begin
					if (ok) begin
						rf_d = '0;
						if (rate_q >= pref_e) begin
							rok_d = '0;
						end else if (rok_inc >= climb_q) begin
							rok_d     = '0;
							apply_req = 1'b1;
							target    = tier_up(rate_q, pref_e);
						end else begin
							rok_d = rok_inc;
						end
					end else begin
						rok_d = '0;
						// No fallback while backing off, nor below the 6M tier.
						if (lvl_q == '0 && !cooling && rate_q >= RATE_6M) begin
							if (rf_inc >= drop_q) begin
								rf_d      = '0;
								apply_req = 1'b1;
								target    = tier_down(rate_q);
							end else begin
								rf_d = rf_inc;
							end
						end
					end
				end
				// Backoff escalation for bridge sends that are not discovery.
				if (cnc) begin
					if (evt_s1.delivered) begin
						txf_d = '0;
						lvl_d = '0;
						end_d = '0;
					end else if (evt_s1.got_reply) begin
						if (txf_inc >= fails_q) begin
							txf_d = '0;
							lvl_d = lvl_up;
							end_d = now_tk + TICK_BITS'(cool_ticks);
							stop  = evt_s1.session_open;
						end else begin
							txf_d = txf_inc;
						end
					end else begin
						stop = evt_s1.session_open;
					end
				end
				// A rate command only goes out when the link can take it.
				changed = apply_req && evt_s1.link_ready && (target != rate_q);
				if (changed) begin
					rate_d = target;
				end
			end
			OP_RELOAD: begin
				rate_d  = pref_e;
				rf_d    = '0;
				rok_d   = '0;
				changed = evt_s1.link_ready;
			end
			OP_CLEAR: begin
				txf_d = '0;
				lvl_d = '0;
				end_d = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pref_q    <= RATE_11M;
			tick_hz_q <= 10'd1000;
			climb_q   <= 8'd32;
			drop_q    <= 8'd3;
			fails_q   <= 8'd2;
			vld_s1    <= 1'b0;
			res_vld_q <= 1'b0;
			rate_q    <= RATE_11M;
			rf_q      <= '0;
			rok_q     <= '0;
			txf_q     <= '0;
			lvl_q     <= '0;
			end_q     <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_PREF_RATE: pref_q    <= cfg_wdata[3:0];
					REG_TICK_HZ:   tick_hz_q <= cfg_wdata;
					REG_CLIMB:     climb_q   <= cfg_wdata[7:0];
					REG_DROP:      drop_q    <= cfg_wdata[7:0];
					REG_FAILS:     fails_q   <= cfg_wdata[7:0];
					default: begin
					end
				endcase
			end
			if (evt_valid && !evt_stall) begin
				vld_s1 <= 1'b1;
			end else if (advance) begin
				vld_s1 <= 1'b0;
			end
			if (fire) begin
				res_vld_q <= 1'b1;
			end else if (!res_stall) begin
				res_vld_q <= 1'b0;
			end
			if (fire) begin
				rate_q <= rate_d;
				rf_q   <= rf_d;
				rok_q  <= rok_d;
				txf_q  <= txf_d;
				lvl_q  <= lvl_d;
				end_q  <= end_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (evt_valid && !evt_stall) begin
			evt_s1 <= evt;
		end
		if (fire) begin
			res_q.send_allowed     <= allowed;
			res_q.attempts_allowed <= attempts;
			res_q.current_rate     <= rate_d;
			res_q.rate_changed     <= changed;
			res_q.close_session    <= stop;
			res_q.cooldown_stage   <= lvl_d;
		end
	end

endmodule

`default_nettype wire

// ===== sv/lrftb_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lrftb_checker
	import lrftb_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic evt_valid,
	input wire logic evt_stall,
	input wire evt_t evt,
	input wire logic res_valid,
	input wire logic res_stall,
	input wire res_t res
);

	// Rate tier and cooldown level never leave their ranges.
	a_ranges: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.current_rate <= RATE_MCS3) && (res.cooldown_stage <= LEVEL_MAX))
		else $error("rate tier or cooldown level out of range");

	// Only a pre-send check grants a send, and it always grants an attempt.
	a_grant: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.send_allowed) |->
			(res.attempts_allowed == 2'd1 || res.attempts_allowed == 2'd2))
		else $error("send granted without attempts");

	// A close request comes from a send outcome, never from a pre-send check.
	a_stop_excl: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.close_session) |-> (res.attempts_allowed == 2'd0))
		else $error("close request on a pre-send result");

	// A stalled result holds.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_stall) |=> (res_valid && $stable(res)))
		else $error("stalled result changed");

	// A stalled event holds until it is taken.
	a_evt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(evt_valid && evt_stall) |=> (evt_valid && $stable(evt)))
		else $error("stalled event changed");

endmodule

bind link_rate_fallback_and_tx_backoff lrftb_checker u_lrftb_checker (.*);

`default_nettype wire

// ===== tb/link_rate_fallback_and_tx_backoff_tb.sv =====
`timescale 1ns / 1ps

module link_rate_fallback_and_tx_backoff_tb
	import lrftb_pkg::*;
();

	// Each side idles in about this many cycles of a hundred while gaps are on.
	localparam int unsigned STALL_PCT = 34;
	// Cycles without any transfer on either channel before the run is abandoned.
	localparam int unsigned QUIET_LIMIT = 2000;
	localparam int unsigned PHASES = 7;
	localparam int unsigned PHASE_ITEMS = 175;
	localparam int unsigned SHOWN_MAX = 10;

	// One row of the directed table. Where typed is set, want holds the result
	// written out by hand; otherwise the predictor supplies it.
	typedef struct {
		evt_t ev;
		bit   typed;
		res_t want;
	} dir_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  evt_valid = 1'b0;
	logic                  evt_stall;
	evt_t                  evt = '0;
	logic                  res_valid;
	logic                  res_stall = 1'b0;
	res_t                  res;

	// Register copies held by the predictor, at their reset values.
	logic [3:0] pref_rate_reg = 4'd3;
	logic [9:0] tick_hz_reg = 10'd1000;
	logic [7:0] climb_reg = 8'd32;
	logic [7:0] drop_reg = 8'd3;
	logic [7:0] fails_reg = 8'd2;

	// Predicted state of the block, at its reset values.
	logic [3:0]  rate_tier = 4'd3;
	logic [7:0]  rate_fail_streak = '0;
	logic [7:0]  rate_ok_streak = '0;
	logic [7:0]  send_fail_streak = '0;
	logic [2:0]  backoff_level = '0;
	logic [31:0] backoff_end = '0;

	res_t pending_results[$];
	int unsigned fail_count = 0;
	int unsigned shown_count = 0;
	int unsigned quiet_cycles = 0;
	bit gaps_on = 1'b1;

	// Random stimulus keeps its own notion of time and a run flag that switches
	// between mostly clean and mostly failing sends.
	logic [31:0] tick_base = '0;
	bit good_run = 1'b1;

	always #10 clk = ~clk;

	link_rate_fallback_and_tx_backoff uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.evt_valid (evt_valid),
		.evt_stall (evt_stall),
		.evt       (evt),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	// The flags are, from the top bit down: to_bridge_peer, discovery,
	// delivered, got_reply, session_open, link_ready.
	function automatic evt_t mk_evt(input op_t op, input logic [31:0] now,
			input logic [5:0] flags);
		evt_t e;
		e.operation = op;
		e.now_ticks = now;
		e.to_bridge_peer = flags[5];
		e.discovery = flags[4];
		e.delivered = flags[3];
		e.got_reply = flags[2];
		e.session_open = flags[1];
		e.link_ready = flags[0];
		return e;
	endfunction

	function automatic res_t mk_res(input logic allowed, input logic [1:0] attempts,
			input logic [3:0] rate, input logic changed, input logic stop,
			input logic [2:0] stage);
		res_t r;
		r.send_allowed = allowed;
		r.attempts_allowed = attempts;
		r.current_rate = rate;
		r.rate_changed = changed;
		r.close_session = stop;
		r.cooldown_stage = stage;
		return r;
	endfunction

	// Applies one event to the predicted state and returns the result the block
	// should give for it.
	function automatic res_t link_policy_step(input evt_t e);
		res_t r;
		logic bridge_cmd;
		logic clean;
		logic cooling;
		logic [3:0] ceiling;
		logic [3:0] target;
		int unsigned span_ms;
		int unsigned span_ticks;
		r = '0;
		bridge_cmd = e.to_bridge_peer && !e.discovery;
		cooling = (backoff_end != 0) && (e.now_ticks < backoff_end);
		// A preferred tier above the top one falls back to the 11M floor.
		ceiling = (pref_rate_reg > RATE_MCS3) ? RATE_11M : pref_rate_reg;
		case (e.operation)
			OP_PRECHECK: begin
				r.send_allowed = !(bridge_cmd && cooling);
				r.attempts_allowed = (e.discovery || send_fail_streak != 0 ||
					backoff_level != 0) ? 2'd1 : 2'd2;
			end
			OP_OUTCOME: begin
				// Discovery sends always count as failures for rate adaptation.
				clean = e.delivered && !e.discovery;
				if (e.to_bridge_peer) begin
					if (clean) begin
						rate_fail_streak = '0;
						if (rate_tier >= ceiling) begin
							rate_ok_streak = '0;
						end else begin
							rate_ok_streak = rate_ok_streak + 8'd1;
							if (rate_ok_streak >= climb_reg) begin
								rate_ok_streak = '0;
								if (rate_tier == RATE_MCS0) begin
									target = (ceiling >= RATE_MCS3) ? RATE_MCS3 : ceiling;
								end else if (rate_tier >= RATE_6M && rate_tier < RATE_MCS0) begin
									target = rate_tier + 4'd1;
								end else if (rate_tier < RATE_6M) begin
									target = RATE_6M;
								end else begin
									target = ceiling;
								end
								if (target != rate_tier && e.link_ready) begin
									rate_tier = target;
									r.rate_changed = 1'b1;
								end
							end
						end
					end else begin
						rate_ok_streak = '0;
						// No fallback while backing off, and never below 6M.
						if (backoff_level == 0 && !cooling && rate_tier >= RATE_6M) begin
							rate_fail_streak = rate_fail_streak + 8'd1;
							if (rate_fail_streak >= drop_reg) begin
								rate_fail_streak = '0;
								if (rate_tier >= RATE_MCS3) begin
									target = RATE_MCS0;
								end else if (rate_tier == RATE_MCS0) begin
									target = RATE_24M;
								end else begin
									target = rate_tier - 4'd1;
								end
								if (target != rate_tier && e.link_ready) begin
									rate_tier = target;
									r.rate_changed = 1'b1;
								end
							end
						end
					end
				end
				if (bridge_cmd) begin
					if (e.delivered) begin
						send_fail_streak = '0;
						backoff_level = '0;
						backoff_end = '0;
					end else if (e.got_reply) begin
						send_fail_streak = send_fail_streak + 8'd1;
						if (send_fail_streak >= fails_reg) begin
							send_fail_streak = '0;
							if (backoff_level < LEVEL_MAX) begin
								backoff_level = backoff_level + 3'd1;
							end
							case (backoff_level)
								3'd1:    span_ms = 1000;
								3'd2:    span_ms = 2000;
								3'd3:    span_ms = 5000;
								default: span_ms = 15000;
							endcase
							span_ticks = (span_ms * tick_hz_reg) / 1000;
							backoff_end = e.now_ticks + span_ticks[31:0];
							r.close_session = e.session_open;
						end
					end else begin
						r.close_session = e.session_open;
					end
				end
			end
			OP_RELOAD: begin
				rate_tier = ceiling;
				rate_fail_streak = '0;
				rate_ok_streak = '0;
				r.rate_changed = e.link_ready;
			end
			default: begin
				send_fail_streak = '0;
				backoff_level = '0;
				backoff_end = '0;
			end
		endcase
		r.current_rate = rate_tier;
		r.cooldown_stage = backoff_level;
		return r;
	endfunction

	// Mostly sends to the bridge peer in runs of clean or failing outcomes, with
	// time creeping forward, and now and then a jump, a wrap or a random tick.
	function automatic evt_t random_event();
		evt_t e;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 27) begin
			e.operation = OP_PRECHECK;
		end else if (pick < 92) begin
			e.operation = OP_OUTCOME;
		end else if (pick < 96) begin
			e.operation = OP_RELOAD;
		end else begin
			e.operation = OP_CLEAR;
		end
		if ($urandom_range(0, 29) == 0) begin
			good_run = !good_run;
		end
		pick = $urandom_range(0, 99);
		if (pick < 3) begin
			tick_base = $urandom;
		end else if (pick < 5) begin
			tick_base = 32'hFFFF_FFFF - $urandom_range(0, 3000);
		end else if (pick < 8) begin
			tick_base = tick_base + $urandom_range(0, 20000);
		end else begin
			tick_base = tick_base + $urandom_range(0, 40);
		end
		e.now_ticks = tick_base;
		e.to_bridge_peer = ($urandom_range(0, 99) < 80);
		e.discovery = ($urandom_range(0, 99) < (good_run ? 3 : 15));
		e.delivered = ($urandom_range(0, 99) < (good_run ? 97 : 25));
		e.got_reply = ($urandom_range(0, 99) < 75);
		e.session_open = ($urandom_range(0, 1) == 1);
		e.link_ready = ($urandom_range(0, 99) < 85);
		return e;
	endfunction

	// Called at a falling edge. Idles for a random number of cycles, then holds
	// the event until the block takes it, and records the result it should give.
	task automatic send_item(input evt_t e, input bit typed, input res_t want);
		res_t predicted;
		while (gaps_on && $urandom_range(0, 99) < STALL_PCT) begin
			evt_valid <= 1'b0;
			@(negedge clk);
		end
		evt_valid <= 1'b1;
		evt <= e;
		do @(posedge clk); while (evt_stall);
		predicted = link_policy_step(e);
		pending_results.push_back(typed ? want : predicted);
		@(negedge clk);
	endtask

	// Called at a falling edge with the block idle. The predictor copy changes
	// at once since no event is in flight.
	task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= value;
		case (idx)
			REG_PREF_RATE: pref_rate_reg = value[3:0];
			REG_TICK_HZ:   tick_hz_reg = value[9:0];
			REG_CLIMB:     climb_reg = value[7:0];
			REG_DROP:      drop_reg = value[7:0];
			default:       fails_reg = value[7:0];
		endcase
		@(negedge clk);
	endtask

	task automatic load_setting(input logic [3:0] pref, input logic [9:0] hz,
			input logic [7:0] climb, input logic [7:0] drop, input logic [7:0] fails);
		write_reg(REG_PREF_RATE, CFG_DATA_W'(pref));
		write_reg(REG_TICK_HZ, hz);
		write_reg(REG_CLIMB, CFG_DATA_W'(climb));
		write_reg(REG_DROP, CFG_DATA_W'(drop));
		write_reg(REG_FAILS, CFG_DATA_W'(fails));
		cfg_we <= 1'b0;
	endtask

	// The result side stalls on its own random schedule, set at falling edges.
	always @(negedge clk) begin
		res_stall <= gaps_on && ($urandom_range(0, 99) < STALL_PCT);
	end

	// Every result transfer is matched against the oldest outstanding one.
	always @(posedge clk) begin : check_results
		res_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_results.size() == 0) begin
				fail_count++;
				if (shown_count < SHOWN_MAX) begin
					shown_count++;
					$write("%0t: result with nothing outstanding: allowed=%0d attempts=%0d",
						$realtime, res.send_allowed, res.attempts_allowed);
					$display(" rate=%0d changed=%0d close=%0d stage=%0d",
						res.current_rate, res.rate_changed, res.close_session,
						res.cooldown_stage);
				end
			end else begin
				want = pending_results.pop_front();
				if (res.send_allowed !== want.send_allowed ||
						res.attempts_allowed !== want.attempts_allowed ||
						res.current_rate !== want.current_rate ||
						res.rate_changed !== want.rate_changed ||
						res.close_session !== want.close_session ||
						res.cooldown_stage !== want.cooldown_stage) begin
					fail_count++;
					if (shown_count < SHOWN_MAX) begin
						shown_count++;
						$write("%0t: result mismatch (expected/actual): allowed %0d/%0d",
							$realtime, want.send_allowed, res.send_allowed);
						$write(" attempts %0d/%0d rate %0d/%0d",
							want.attempts_allowed, res.attempts_allowed,
							want.current_rate, res.current_rate);
						$display(" changed %0d/%0d close %0d/%0d stage %0d/%0d",
							want.rate_changed, res.rate_changed,
							want.close_session, res.close_session,
							want.cooldown_stage, res.cooldown_stage);
					end
				end
			end
		end
	end

	// A run that stops moving on both channels is a failure.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((evt_valid && !evt_stall) || (res_valid && !res_stall)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	initial begin : stimulus
		dir_row_t rows[$];
		int unsigned ph;
		int unsigned n;

		// Directed events under the reset settings. Results that follow straight
		// from reset are written out; the rest come from the predictor.
		// Plain check right after reset: allowed with two attempts.
		rows.push_back('{mk_evt(OP_PRECHECK, 32'h0, 6'b100000), 1'b1,
			mk_res(1'b1, 2'd2, 4'd3, 1'b0, 1'b0, 3'd0)});
		// Discovery with every field at its top value gets a single attempt.
		rows.push_back('{mk_evt(OP_PRECHECK, 32'hFFFF_FFFF, 6'b111111), 1'b1,
			mk_res(1'b1, 2'd1, 4'd3, 1'b0, 1'b0, 3'd0)});
		// Reload reports a rate command exactly when the link is ready.
		rows.push_back('{mk_evt(OP_RELOAD, 32'd12345, 6'b000001), 1'b1,
			mk_res(1'b0, 2'd0, 4'd3, 1'b1, 1'b0, 3'd0)});
		rows.push_back('{mk_evt(OP_RELOAD, 32'h0, 6'b111110), 1'b1,
			mk_res(1'b0, 2'd0, 4'd3, 1'b0, 1'b0, 3'd0)});
		rows.push_back('{mk_evt(OP_CLEAR, 32'hFFFF_FFFF, 6'b111111), 1'b1,
			mk_res(1'b0, 2'd0, 4'd3, 1'b0, 1'b0, 3'd0)});
		// Two replied failures escalate the cooldown and ask for a close.
		rows.push_back('{mk_evt(OP_OUTCOME, 32'd100, 6'b100111), 1'b0, '0});
		rows.push_back('{mk_evt(OP_PRECHECK, 32'd110, 6'b100001), 1'b0, '0});
		rows.push_back('{mk_evt(OP_OUTCOME, 32'd200, 6'b100111), 1'b0, '0});
		// While cooling only non-discovery bridge traffic is refused.
		rows.push_back('{mk_evt(OP_PRECHECK, 32'd300, 6'b100001), 1'b0, '0});
		rows.push_back('{mk_evt(OP_PRECHECK, 32'd300, 6'b110001), 1'b0, '0});
		rows.push_back('{mk_evt(OP_PRECHECK, 32'd300, 6'b000001), 1'b0, '0});
		// No reply: a close only when the session is open.
		rows.push_back('{mk_evt(OP_OUTCOME, 32'd400, 6'b100011), 1'b0, '0});
		rows.push_back('{mk_evt(OP_OUTCOME, 32'd410, 6'b100001), 1'b0, '0});
		// A failed discovery send does not touch the cooldown.
		rows.push_back('{mk_evt(OP_OUTCOME, 32'd420, 6'b110111), 1'b0, '0});
		// A delivered bridge send clears the cooldown.
		rows.push_back('{mk_evt(OP_OUTCOME, 32'd1200, 6'b101111), 1'b0, '0});
		// Escalation just below the top of the tick range wraps the end tick.
		rows.push_back('{mk_evt(OP_OUTCOME, 32'hFFFF_FF00, 6'b100101), 1'b0, '0});
		rows.push_back('{mk_evt(OP_OUTCOME, 32'hFFFF_FF00, 6'b100110), 1'b0, '0});
		rows.push_back('{mk_evt(OP_PRECHECK, 32'hFFFF_FF10, 6'b100001), 1'b0, '0});
		rows.push_back('{mk_evt(OP_PRECHECK, 32'h0000_0100, 6'b100001), 1'b0, '0});
		// An outcome to another peer changes nothing.
		rows.push_back('{mk_evt(OP_OUTCOME, 32'h8000_0000, 6'b011111), 1'b0, '0});
		rows.push_back('{mk_evt(OP_CLEAR, 32'h0, 6'b000000), 1'b0, '0});

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (rows[i]) begin
			send_item(rows[i].ev, rows[i].typed, rows[i].want);
		end

		// Random phases, each under its own settings. Settings change only with
		// the block drained: the sender holds off until every outstanding result
		// has been taken.
		for (ph = 0; ph < PHASES; ph++) begin
			if (ph != 0) begin
				evt_valid <= 1'b0;
				while (pending_results.size() != 0) @(negedge clk);
				repeat (3) @(negedge clk);
				case (ph)
					1: load_setting(4'd8, 10'd1000, 8'd1, 8'd1, 8'd1);
					2: load_setting(4'd8, 10'd1, 8'd4, 8'd2, 8'd3);
					3: load_setting(4'd15, 10'd1023, 8'd255, 8'd255, 8'd255);
					4: load_setting(4'd7, 10'd0, 8'd0, 8'd0, 8'd0);
					5: load_setting(4'd0, 10'd500, 8'd8, 8'd3, 8'd2);
					default: load_setting(4'($urandom_range(0, 15)),
						10'($urandom_range(0, 1023)), 8'($urandom_range(0, 255)),
						8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
				endcase
			end
			// One whole phase runs with neither side idling.
			gaps_on = (ph != 4);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				send_item(random_event(), 1'b0, '0);
			end
		end

		evt_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/lrftb_pkg.sv
sv/link_rate_fallback_and_tx_backoff.sv
sv/lrftb_checker.sv
tb/link_rate_fallback_and_tx_backoff_tb.sv
